### rtl/core/ptts_pkg.sv
`default_nettype none
package ptts_pkg;
    localparam int NUM_TASKS = 8;
    localparam int NUM_PRIO = 32;
    localparam int TW = $clog2(NUM_TASKS);
    localparam int PW = $clog2(NUM_PRIO);
    localparam int LW = $clog2(NUM_TASKS + 1);
    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam logic [15:0] SLICE_RESET = 16'd10;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_START  = 3'd1,
        REQ_TICK   = 3'd2,
        REQ_DELAY  = 3'd3,
        REQ_LOCK   = 3'd4,
        REQ_UNLOCK = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_COUNT, ST_WAKE, ST_ORDER, ST_SLICE, ST_FIND, ST_REMOVE,
        ST_APPEND, ST_PICK, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic count;
        logic wake;
        logic order;
        logic slice;
        logic find_step;
        logic remove;
        logic append_cur;
        logic pick;
        logic clr_idx;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic is_delay;
        logic is_unlock0;
        logic is_start;
        logic idx_last;
        logic need_rotate;
        logic found;
        logic rotate_done;
    } sts_t;
endpackage
`default_nettype wire

### rtl/core/ptts_ctrl.sv
`default_nettype none
module ptts_ctrl
    import ptts_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_fire,
    input  wire logic out_fire,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      out_valid
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        busy = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                cmd.clr_idx = 1'b1;
                if (sts.is_tick) state_next = ST_COUNT;
                else if (sts.is_delay) state_next = ST_FIND;
                else if (sts.is_start || sts.is_unlock0) state_next = ST_PICK;
                else state_next = ST_OUT;
            end
            ST_COUNT: begin
                cmd.count = 1'b1;
                cmd.clr_idx = 1'b1;
                state_next = ST_WAKE;
            end
            ST_WAKE: begin
                cmd.wake = 1'b1;
                if (sts.idx_last) state_next = ST_ORDER;
            end
            ST_ORDER: begin
                cmd.order = 1'b1;
                cmd.clr_idx = 1'b1;
                state_next = ST_SLICE;
            end
            ST_SLICE: begin
                cmd.slice = 1'b1;
                cmd.clr_idx = 1'b1;
                state_next = sts.need_rotate ? ST_FIND : ST_PICK;
            end
            ST_FIND: begin
                cmd.find_step = 1'b1;
                if (sts.found) state_next = ST_REMOVE;
                else if (sts.idx_last) state_next = ST_PICK;
            end
            ST_REMOVE: begin
                cmd.remove = 1'b1;
                state_next = sts.rotate_done ? ST_APPEND : ST_PICK;
            end
            ST_APPEND: begin
                cmd.append_cur = 1'b1;
                state_next = ST_PICK;
            end
            ST_PICK: begin
                cmd.pick = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_fire) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### rtl/core/ptts_dp.sv
`default_nettype none
module ptts_dp
    import ptts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic [2:0]  in_req,
    input  wire logic [2:0]  in_id,
    input  wire logic [4:0]  in_prio,
    input  wire logic [31:0] in_dly,
    input  wire cmd_t        cmd,
    output sts_t             sts,
    output logic [2:0]       running_task,
    output logic             switch_now,
    output logic             none_ready,
    output logic [7:0]       lock_depth
);
    logic [15:0] slice_reload_reg;
    logic [2:0] req_reg;
    logic [TW-1:0] id_reg;
    logic [PW-1:0] prio_reg;
    logic [31:0] dly_reg;
    logic [NUM_PRIO-1:0] ready_map_reg;
    logic [TW-1:0] qhead_reg [NUM_PRIO];
    logic [TW-1:0] qtail_reg [NUM_PRIO];
    logic [LW-1:0] qlen_reg [NUM_PRIO];
    logic [TW-1:0] nxt_reg [NUM_TASKS];
    logic [PW-1:0] tprio_reg [NUM_TASKS];
    logic [31:0] sleft_reg [NUM_TASKS];
    logic [NUM_TASKS-1:0] sleeping_reg, queued_reg, expired_reg;
    logic [TW-1:0] sorder_reg [NUM_TASKS];
    logic [15:0] slice_reg [NUM_TASKS];
    logic [TW-1:0] cur_reg, before_reg, prev_reg;
    logic [7:0] lock_reg;
    logic [TW:0] idx_reg;
    logic rot_reg;

    logic [TW-1:0] cur;
    logic [PW-1:0] cp, wp;
    logic [TW-1:0] widx;
    logic wake_hit;
    logic [TW-1:0] ucnt [NUM_TASKS];
    logic [PW-1:0] pick_p;
    logic pick_ok;

    assign cur = cur_reg;
    assign cp = tprio_reg[cur];
    assign widx = idx_reg[TW-1:0];

    always_comb begin
        wake_hit = 1'b0;
        wp = '0;
        for (int t = 0; t < NUM_TASKS; t++) begin
            if (!wake_hit && sleeping_reg[t] && expired_reg[t] && sorder_reg[t] == widx) begin
                wake_hit = 1'b1;
                wp = tprio_reg[t];
            end
        end
        for (int t = 0; t < NUM_TASKS; t++) begin
            ucnt[t] = '0;
            for (int u = 0; u < NUM_TASKS; u++)
                if (sleeping_reg[u] && sorder_reg[u] < sorder_reg[t])
                    ucnt[t] = ucnt[t] + TW'(1);
        end
        pick_ok = 1'b0;
        pick_p = '0;
        for (int p = NUM_PRIO - 1; p >= 0; p--)
            if (ready_map_reg[p]) begin
                pick_ok = 1'b1;
                pick_p = PW'(p);
            end
    end

    logic [TW-1:0] wtask;
    always_comb begin
        wtask = '0;
        for (int t = NUM_TASKS - 1; t >= 0; t--)
            if (sleeping_reg[t] && expired_reg[t] && sorder_reg[t] == widx) wtask = TW'(t);
    end

    assign sts.is_tick = (req_reg == REQ_TICK);
    assign sts.is_delay = (req_reg == REQ_DELAY);
    assign sts.is_start = (req_reg == REQ_START);
    assign sts.is_unlock0 = (req_reg == REQ_UNLOCK) && (lock_reg == 8'd1);
    assign sts.idx_last = (idx_reg == (TW+1)'(NUM_TASKS - 1));
    assign sts.need_rotate = queued_reg[cur] && (slice_reg[cur] <= 16'd1);
    assign sts.found = queued_reg[cur] &&
                       ((qhead_reg[cp] == cur) || (nxt_reg[prev_reg] == cur));
    assign sts.rotate_done = rot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_reload_reg <= SLICE_RESET;
            ready_map_reg <= '0;
            sleeping_reg <= '0;
            queued_reg <= '0;
            cur_reg <= '0;
            lock_reg <= '0;
            for (int i = 0; i < NUM_PRIO; i++) qlen_reg[i] <= '0;
            for (int i = 0; i < NUM_TASKS; i++) begin
                sleft_reg[i] <= '0;
                sorder_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) slice_reload_reg <= cfg_wr_data;
            if (cmd.clr_idx) idx_reg <= '0;
            if (cmd.load) begin
                req_reg <= in_req;
                id_reg <= in_id[TW-1:0];
                prio_reg <= in_prio[PW-1:0];
                dly_reg <= in_dly;
                before_reg <= cur_reg;
                rot_reg <= 1'b0;
            end
            if (cmd.exec) begin
                prev_reg <= qhead_reg[cp];
                case (req_reg)
                    REQ_ADD: begin
                        if (!queued_reg[id_reg] && !sleeping_reg[id_reg]) begin
                            tprio_reg[id_reg] <= prio_reg;
                            slice_reg[id_reg] <= slice_reload_reg;
                            sleft_reg[id_reg] <= '0;
                            if (qlen_reg[prio_reg] == '0) qhead_reg[prio_reg] <= id_reg;
                            else nxt_reg[qtail_reg[prio_reg]] <= id_reg;
                            qtail_reg[prio_reg] <= id_reg;
                            qlen_reg[prio_reg] <= qlen_reg[prio_reg] + LW'(1);
                            queued_reg[id_reg] <= 1'b1;
                            ready_map_reg[prio_reg] <= 1'b1;
                        end
                    end
                    REQ_LOCK: if (lock_reg != LOCK_MAX) lock_reg <= lock_reg + 8'd1;
                    REQ_UNLOCK: begin
                        if (lock_reg != 8'd0) lock_reg <= lock_reg - 8'd1;
                    end
                    REQ_DELAY: begin
                        if (queued_reg[cur]) begin
                            for (int t = 0; t < NUM_TASKS; t++)
                                if (sleeping_reg[t]) sorder_reg[t] <= sorder_reg[t] + TW'(1);
                            sorder_reg[cur] <= '0;
                            sleft_reg[cur] <= (dly_reg == 32'd0) ? 32'd1 : dly_reg;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.count) begin
                for (int t = 0; t < NUM_TASKS; t++) begin
                    expired_reg[t] <= sleeping_reg[t] &&
                        (sleft_reg[t] == 32'd0 || sleft_reg[t] == 32'd1);
                    if (sleeping_reg[t] && sleft_reg[t] != 32'd0)
                        sleft_reg[t] <= sleft_reg[t] - 32'd1;
                end
            end
            if (cmd.wake) begin
                idx_reg <= idx_reg + (TW+1)'(1);
                if (wake_hit) begin
                    sleeping_reg[wtask] <= 1'b0;
                    if (qlen_reg[wp] == '0) qhead_reg[wp] <= wtask;
                    else nxt_reg[qtail_reg[wp]] <= wtask;
                    qtail_reg[wp] <= wtask;
                    qlen_reg[wp] <= qlen_reg[wp] + LW'(1);
                    queued_reg[wtask] <= 1'b1;
                    ready_map_reg[wp] <= 1'b1;
                end
            end
            if (cmd.order) begin
                for (int t = 0; t < NUM_TASKS; t++)
                    sorder_reg[t] <= sleeping_reg[t] ? ucnt[t] : '0;
            end
            if (cmd.slice) begin
                prev_reg <= qhead_reg[cp];
                if (queued_reg[cur]) begin
                    if (slice_reg[cur] <= 16'd1) begin
                        slice_reg[cur] <= slice_reload_reg;
                        rot_reg <= 1'b1;
                    end else slice_reg[cur] <= slice_reg[cur] - 16'd1;
                end
            end
            if (cmd.find_step) begin
                idx_reg <= idx_reg + (TW+1)'(1);
                if (!(qhead_reg[cp] == cur || nxt_reg[prev_reg] == cur))
                    prev_reg <= nxt_reg[prev_reg];
            end
            if (cmd.remove) begin
                if (qhead_reg[cp] == cur) qhead_reg[cp] <= nxt_reg[cur];
                else begin
                    nxt_reg[prev_reg] <= nxt_reg[cur];
                    if (qtail_reg[cp] == cur) qtail_reg[cp] <= prev_reg;
                end
                qlen_reg[cp] <= qlen_reg[cp] - LW'(1);
                queued_reg[cur] <= 1'b0;
                if (qlen_reg[cp] == LW'(1)) ready_map_reg[cp] <= 1'b0;
                if (req_reg == REQ_DELAY) sleeping_reg[cur] <= 1'b1;
            end
            if (cmd.append_cur) begin
                if (qlen_reg[cp] == '0) qhead_reg[cp] <= cur;
                else nxt_reg[qtail_reg[cp]] <= cur;
                qtail_reg[cp] <= cur;
                qlen_reg[cp] <= qlen_reg[cp] + LW'(1);
                queued_reg[cur] <= 1'b1;
                ready_map_reg[cp] <= 1'b1;
            end
            if (cmd.pick) begin
                if (pick_ok && (req_reg == REQ_START || lock_reg == 8'd0))
                    cur_reg <= qhead_reg[pick_p];
            end
        end
    end

    assign running_task = 3'(cur_reg);
    assign switch_now = (cur_reg != before_reg);
    assign none_ready = (ready_map_reg == '0);
    assign lock_depth = lock_reg;
endmodule
`default_nettype wire

### rtl/core/priority_timeslice_task_scheduler.sv
// Hardware task scheduler with per-priority FIFO ready queues and round-robin slices.
// Requests arrive on the s_axis channel; each accepted transaction gives exactly one
// result transaction on the m_axis channel with the running task, a switch flag,
// an empty flag and the lock depth.
// One request is handled at a time. The wake pass of a tick visits one of the eight
// wake-order slots per cycle, and each queue search walks one link per cycle.
// The next request is accepted in the cycle after the result transaction.
// s_axis_tready is high only while the block is idle; a result held by a stalled
// receiver keeps the block busy until it is taken.
// Synchronous active-low reset empties all queues, wakes nothing, clears the lock
// count, selects task 0 and sets the slice reload to 10 ticks.
// The slice reload register is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
`default_nettype none
module priority_timeslice_task_scheduler
    import ptts_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // req_type[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    // task_id[2:0], task_priority[7:3], sleep_ticks[39:8]
    input  wire logic [39:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // running_task[2:0], switch_now[3], none_ready[4], lock_depth[12:5], zero
    output logic [15:0]      m_axis_tdata
);
    cmd_t cmd;
    sts_t sts;
    logic busy;
    logic [2:0] rt;
    logic sw, nr;
    logic [7:0] ld;

    assign s_axis_tready = !busy;

    ptts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_fire(s_axis_tvalid && !busy),
        .out_fire(m_axis_tvalid && m_axis_tready),
        .sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
    );

    ptts_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_req(s_axis_tuser), .in_id(s_axis_tdata[2:0]),
        .in_prio(s_axis_tdata[7:3]), .in_dly(s_axis_tdata[39:8]),
        .cmd(cmd), .sts(sts),
        .running_task(rt), .switch_now(sw), .none_ready(nr), .lock_depth(ld)
    );

    assign m_axis_tdata = {3'b000, ld, nr, sw, rt};
endmodule
`default_nettype wire
